// ===== rtl/core/mme_pkg.sv =====
package mme_pkg;
	localparam int DIM_MAX  = 64;
	localparam int IDX_W    = 6;
	localparam int DIMS_W   = 7;
	localparam int IN_W     = 16;
	localparam int MAG_W    = 16;
	localparam int SUM_W    = 26;
	localparam int PROD_W   = 2 * SUM_W;
	localparam int ACC_W    = 60;
	localparam int ROOT_W   = 30;
	localparam int NUM_W    = 42;
	localparam int OUT_W    = 16;
	localparam int FRAC_W   = 15;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
	localparam logic [OUT_W-1:0] ONE_Q15 = 16'h8000;
endpackage

// ===== rtl/core/mode_magnitude_embedding_top.sv =====
// Streams quaternion elements (w_part, x_part) and, per character of dims_in_use
// modes, accumulates each element magnitude into a per-mode sum; an end_of_chunk
// word emits one L2-normalized unsigned Q1.15 value per mode and clears the sums. One
// shared multiplier, one iterative square root and one iterative divider do all
// arithmetic under a sequencer, and in_ready is low while a word is in work. An
// element that completes a character also takes a pass over the modes. The end of
// a chunk takes a pass over the modes for the sum of squares, a square root for
// the norm, then one division per emitted value plus output stalls.
module mode_magnitude_embedding_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [mme_pkg::DIMS_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [mme_pkg::IN_W-1:0] w_part,
	input  logic signed [mme_pkg::IN_W-1:0] x_part,
	input  logic                         carries_element,
	input  logic                         end_of_chunk,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mme_pkg::IDX_W-1:0]    mode_index,
	output logic [mme_pkg::OUT_W-1:0]    norm_value,
	output logic                         last_value
);
	typedef enum logic [3:0] {
		S_IDLE, S_MW, S_MX, S_SQ0, S_SQ, S_CRD, S_CWR, S_QRD, S_QMUL, S_QACC,
		S_NSQ0, S_NSQ, S_DRD, S_DST, S_DIV, S_OUT
	} state_t;

	state_t state_q;
	logic signed [mme_pkg::IN_W-1:0] w_q, x_q;
	logic                            eoc_q;
	logic [mme_pkg::DIMS_W-1:0]      dims_q, dims;
	logic [mme_pkg::IDX_W-1:0]       pos_q, j_q;
	logic [mme_pkg::DIM_MAX-1:0]     vld_q;
	logic [mme_pkg::PROD_W-1:0]      prod_q;
	logic [mme_pkg::ACC_W-1:0]       acc_q;
	logic [mme_pkg::ROOT_W-1:0]      n_q;
	logic [mme_pkg::SUM_W-1:0]       sum_mem [mme_pkg::DIM_MAX];
	logic [mme_pkg::MAG_W-1:0]       pend_mem [mme_pkg::DIM_MAX];
	logic [mme_pkg::SUM_W-1:0]       sum_rd_q, s_eff;
	logic [mme_pkg::MAG_W-1:0]       pend_rd_q;
	logic [mme_pkg::SUM_W:0]         s_add;
	logic [mme_pkg::SUM_W-1:0]       s_sat, mul_a;
	logic [mme_pkg::IN_W-1:0]        abs_w, abs_x;
	logic                            sq_start, sq_done, dv_start, dv_done;
	logic [mme_pkg::ACC_W-1:0]       sq_op;
	logic [mme_pkg::ROOT_W-1:0]      sq_root;
	logic [mme_pkg::NUM_W-1:0]       dv_num, dv_quot;
	logic                            j_last, pos_last;

	assign dims = (dims_q == '0) ? mme_pkg::DIMS_W'(1) :
		(dims_q > mme_pkg::DIMS_W'(mme_pkg::DIM_MAX)) ?
		mme_pkg::DIMS_W'(mme_pkg::DIM_MAX) : dims_q;
	assign j_last   = ({1'b0, j_q} + mme_pkg::DIMS_W'(1)) == dims;
	assign pos_last = ({1'b0, pos_q} + mme_pkg::DIMS_W'(1)) >= dims;
	assign in_ready = (state_q == S_IDLE);

	assign abs_w = w_q[mme_pkg::IN_W-1] ? mme_pkg::IN_W'(-w_q) : mme_pkg::IN_W'(w_q);
	assign abs_x = x_q[mme_pkg::IN_W-1] ? mme_pkg::IN_W'(-x_q) : mme_pkg::IN_W'(x_q);
	assign s_eff = vld_q[j_q] ? sum_rd_q : '0;
	assign s_add = {1'b0, s_eff} + {{(mme_pkg::SUM_W+1-mme_pkg::MAG_W){1'b0}}, pend_rd_q};
	assign s_sat = s_add[mme_pkg::SUM_W] ? mme_pkg::SUM_MAX : s_add[mme_pkg::SUM_W-1:0];

	always_comb begin
		case (state_q)
			S_MW:    mul_a = mme_pkg::SUM_W'(abs_w);
			S_MX:    mul_a = mme_pkg::SUM_W'(abs_x);
			default: mul_a = s_eff;
		endcase
	end

	assign sq_start = (state_q == S_SQ0) || (state_q == S_NSQ0);
	assign sq_op    = (state_q == S_SQ0) ? acc_q + mme_pkg::ACC_W'(prod_q) : acc_q;
	assign dv_start = (state_q == S_DST) && (n_q != '0);
	assign dv_num   = (mme_pkg::NUM_W'(s_eff) << mme_pkg::FRAC_W) +
		mme_pkg::NUM_W'(n_q >> 1);

	mme_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .operand(sq_op),
		.done(sq_done), .root(sq_root)
	);

	mme_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .numer(dv_num), .denom(n_q),
		.done(dv_done), .quot(dv_quot)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_SQ && sq_done)
			pend_mem[pos_q] <= sq_root[mme_pkg::MAG_W-1:0];
		if (state_q == S_CWR)
			sum_mem[j_q] <= s_sat;
		sum_rd_q  <= sum_mem[j_q];
		pend_rd_q <= pend_mem[j_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			dims_q     <= mme_pkg::DIMS_W'(mme_pkg::DIM_MAX);
			pos_q      <= '0;
			j_q        <= '0;
			vld_q      <= '0;
			out_valid  <= 1'b0;
			eoc_q      <= 1'b0;
			w_q        <= '0;
			x_q        <= '0;
			acc_q      <= '0;
			prod_q     <= '0;
			n_q        <= '0;
			mode_index <= '0;
			norm_value <= '0;
			last_value <= 1'b0;
		end else begin
			if (cfg_we)
				dims_q <= cfg_wdata;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						w_q   <= w_part;
						x_q   <= x_part;
						eoc_q <= end_of_chunk;
						acc_q <= '0;
						j_q   <= '0;
						if (carries_element)
							state_q <= S_MW;
						else if (end_of_chunk)
							state_q <= S_QRD;
					end
				end
				S_MW: begin
					prod_q  <= mul_a * mul_a;
					state_q <= S_MX;
				end
				S_MX: begin
					prod_q  <= mul_a * mul_a;
					acc_q   <= mme_pkg::ACC_W'(prod_q);
					state_q <= S_SQ0;
				end
				S_SQ0: state_q <= S_SQ;
				S_SQ: begin
					if (sq_done) begin
						acc_q <= '0;
						j_q   <= '0;
						if (pos_last) begin
							state_q <= S_CRD;
						end else begin
							pos_q   <= pos_q + mme_pkg::IDX_W'(1);
							state_q <= eoc_q ? S_QRD : S_IDLE;
						end
					end
				end
				S_CRD: state_q <= S_CWR;
				S_CWR: begin
					vld_q[j_q] <= 1'b1;
					if (j_last) begin
						pos_q   <= '0;
						j_q     <= '0;
						state_q <= eoc_q ? S_QRD : S_IDLE;
					end else begin
						j_q     <= j_q + mme_pkg::IDX_W'(1);
						state_q <= S_CRD;
					end
				end
				S_QRD: state_q <= S_QMUL;
				S_QMUL: begin
					prod_q  <= mul_a * mul_a;
					state_q <= S_QACC;
				end
				S_QACC: begin
					acc_q <= acc_q + mme_pkg::ACC_W'(prod_q);
					if (j_last) begin
						j_q     <= '0;
						state_q <= S_NSQ0;
					end else begin
						j_q     <= j_q + mme_pkg::IDX_W'(1);
						state_q <= S_QRD;
					end
				end
				S_NSQ0: state_q <= S_NSQ;
				S_NSQ: begin
					if (sq_done) begin
						n_q     <= sq_root;
						state_q <= S_DRD;
					end
				end
				S_DRD: state_q <= S_DST;
				S_DST: begin
					mode_index <= j_q;
					last_value <= j_last;
					if (n_q == '0) begin
						norm_value <= '0;
						out_valid  <= 1'b1;
						state_q    <= S_OUT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (dv_done) begin
						norm_value <= (dv_quot > mme_pkg::NUM_W'(mme_pkg::ONE_Q15)) ?
							mme_pkg::ONE_Q15 : dv_quot[mme_pkg::OUT_W-1:0];
						out_valid  <= 1'b1;
						state_q    <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (j_last) begin
							vld_q   <= '0;
							pos_q   <= '0;
							j_q     <= '0;
							state_q <= S_IDLE;
						end else begin
							j_q     <= j_q + mme_pkg::IDX_W'(1);
							state_q <= S_DRD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/core/mme_sqrt.sv =====
module mme_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mme_pkg::ACC_W-1:0]     operand,
	output logic                          done,
	output logic [mme_pkg::ROOT_W-1:0]    root
);
	logic [mme_pkg::ACC_W-1:0] v_q, res_q, bit_q, trial;
	logic                      busy_q;
	logic [4:0]                cnt_q;

	assign trial = res_q + bit_q;
	assign root  = res_q[mme_pkg::ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(mme_pkg::ACC_W / 2 - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= operand;
			res_q <= '0;
			bit_q <= {2'b01, {(mme_pkg::ACC_W-2){1'b0}}};
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

// ===== rtl/core/mme_div.sv =====
module mme_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mme_pkg::NUM_W-1:0]     numer,
	input  logic [mme_pkg::ROOT_W-1:0]    denom,
	output logic                          done,
	output logic [mme_pkg::NUM_W-1:0]     quot
);
	logic [mme_pkg::NUM_W-1:0]  num_q;
	logic [mme_pkg::ROOT_W-1:0] den_q, rem_q;
	logic [mme_pkg::ROOT_W:0]   rem_sh;
	logic                       busy_q;
	logic [5:0]                 cnt_q;

	assign rem_sh = {rem_q, num_q[mme_pkg::NUM_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(mme_pkg::NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
			quot  <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= mme_pkg::ROOT_W'(rem_sh - {1'b0, den_q});
				quot  <= {quot[mme_pkg::NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[mme_pkg::ROOT_W-1:0];
				quot  <= {quot[mme_pkg::NUM_W-2:0], 1'b0};
			end
		end
	end
endmodule

// ===== rtl/core/mme_checker.sv =====
module mme_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [mme_pkg::IDX_W-1:0]    mode_index,
	input logic [mme_pkg::OUT_W-1:0]    norm_value,
	input logic                         last_value
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mode_index) && $stable(norm_value))
		else $error("result word changed while stalled");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while result pending");

	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_value |=> !in_ready)
		else $error("input ready before last result");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_value |=> in_ready)
		else $error("not ready after last result");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> norm_value <= mme_pkg::ONE_Q15)
		else $error("normalized value above one");
endmodule

bind mode_magnitude_embedding_top mme_checker u_mme_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .mode_index(mode_index), .norm_value(norm_value),
	.last_value(last_value)
);
